// ===== hw/rtl/erm_pkg.sv =====
package erm_pkg;

  localparam int ANGLE_W       = 17;
  localparam int ELEM_W        = 32;
  localparam int TRIG_FRAC_DEF = 14;

  localparam int CORDIC_STEPS = 28;
  localparam int CW           = 33;   // cordic x/y/z width, Q30 with headroom
  localparam int FULL_TURN    = 46080;
  localparam int QUARTER_TURN = 11520;
  localparam int FW           = 14;   // remainder within a quadrant
  localparam int RAD_W        = 34;
  localparam logic [RAD_W-1:0] RAD_SCALE = 34'd9595049033;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

  localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008
  };

  // angle reduce, quadrant split, radian scale, cordic steps, round/map
  localparam int TRIG_LAT = 3 + CORDIC_STEPS + 1;
  localparam int ROT_LAT  = 5;

  typedef struct packed {
    logic signed [ELEM_W-1:0] e0;
    logic signed [ELEM_W-1:0] e1;
    logic signed [ELEM_W-1:0] e2;
    logic signed [ELEM_W-1:0] e3;
  } row_t;

endpackage

// ===== hw/rtl/erm_trig.sv =====
module erm_trig #(
  parameter int TRIG_FRAC_BITS = erm_pkg::TRIG_FRAC_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic signed [erm_pkg::ANGLE_W-1:0] angle,
  output logic                               out_vld,
  output logic signed [TRIG_FRAC_BITS+1:0]   sin_o,
  output logic signed [TRIG_FRAC_BITS+1:0]   cos_o
);

  localparam int T     = TRIG_FRAC_BITS;
  localparam int TW    = T + 2;
  localparam int CW    = erm_pkg::CW;
  localparam int N     = erm_pkg::CORDIC_STEPS;
  localparam int SH    = 30 - T;
  localparam int FW    = erm_pkg::FW;
  localparam int PW    = FW + erm_pkg::RAD_W;

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  // stage 0: reduce into one turn
  logic signed [17:0] a_ext, a_red;
  logic [15:0]        ang;
  logic               v0;

  always_comb begin
    a_ext = 18'(angle);
    a_red = a_ext;
    if (a_ext < 0) begin
      a_red = a_ext + 18'sd46080;
      if (a_red < 0) begin
        a_red = a_red + 18'sd46080;
      end
    end else if (a_ext >= 18'sd46080) begin
      a_red = a_ext - 18'sd46080;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_vld;
    end
    if (en) begin
      ang <= a_red[15:0];
    end
  end

  // stage 1: quadrant and remainder
  quad_t       q1;
  logic [FW-1:0] f1;
  logic        v1;
  quad_t       q_c;
  logic [15:0] f_c;

  always_comb begin
    if (ang >= 16'd34560) begin
      q_c = QUAD_3;
      f_c = ang - 16'd34560;
    end else if (ang >= 16'd23040) begin
      q_c = QUAD_2;
      f_c = ang - 16'd23040;
    end else if (ang >= 16'd11520) begin
      q_c = QUAD_1;
      f_c = ang - 16'd11520;
    end else begin
      q_c = QUAD_0;
      f_c = ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
    if (en) begin
      q1 <= q_c;
      f1 <= f_c[FW-1:0];
    end
  end

  // stage 2: remainder to radians, Q30
  logic [PW-1:0] prod;
  logic          v2;
  quad_t         q2;
  logic          zero2;
  logic signed [CW-1:0] theta;

  assign prod = PW'(f1) * PW'(erm_pkg::RAD_SCALE) + PW'(32768);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      q2    <= q1;
      zero2 <= (f1 == '0);
      theta <= CW'(prod[PW-1:16]);
    end
  end

  // cordic steps, one per register
  logic signed [CW-1:0] xp [1:N];
  logic signed [CW-1:0] yp [1:N];
  logic signed [CW-1:0] zp [1:N];
  logic                 vp [1:N];
  quad_t                qp [1:N];
  logic                 zrp[1:N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [CW-1:0] xi, yi, zi, at;
    logic                 vi, zri;
    quad_t                qi;
    if (i == 0) begin : g_first
      assign xi  = erm_pkg::CORDIC_GAIN;
      assign yi  = '0;
      assign zi  = theta;
      assign vi  = v2;
      assign qi  = q2;
      assign zri = zero2;
    end else begin : g_rest
      assign xi  = xp[i];
      assign yi  = yp[i];
      assign zi  = zp[i];
      assign vi  = vp[i];
      assign qi  = qp[i];
      assign zri = zrp[i];
    end
    assign at = CW'(erm_pkg::ATAN_Q30[i]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vp[i+1] <= 1'b0;
      end else if (en) begin
        vp[i+1] <= vi;
      end
      if (en) begin
        qp[i+1]  <= qi;
        zrp[i+1] <= zri;
        if (zi >= 0) begin
          xp[i+1] <= xi - (yi >>> i);
          yp[i+1] <= yi + (xi >>> i);
          zp[i+1] <= zi - at;
        end else begin
          xp[i+1] <= xi + (yi >>> i);
          yp[i+1] <= yi - (xi >>> i);
          zp[i+1] <= zi + at;
        end
      end
    end
  end

  // round to trig format and fold the quadrant in
  logic signed [CW-1:0] xr, yr;
  logic signed [TW-1:0] c_r, s_r;

  always_comb begin
    xr = (xp[N] + (CW'(1) <<< (SH - 1))) >>> SH;
    yr = (yp[N] + (CW'(1) <<< (SH - 1))) >>> SH;
    if (zrp[N]) begin
      s_r = '0;
      c_r = TW'(1) <<< T;
    end else begin
      s_r = yr[TW-1:0];
      c_r = xr[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vp[N];
    end
    if (en) begin
      unique case (qp[N])
        QUAD_1: begin
          sin_o <= c_r;
          cos_o <= -s_r;
        end
        QUAD_2: begin
          sin_o <= -s_r;
          cos_o <= -c_r;
        end
        QUAD_3: begin
          sin_o <= -c_r;
          cos_o <= s_r;
        end
        default: begin
          sin_o <= s_r;
          cos_o <= c_r;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/erm_rot.sv =====
module erm_rot #(
  parameter int TRIG_FRAC_BITS = erm_pkg::TRIG_FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic signed [TRIG_FRAC_BITS+1:0]  sx,
  input  logic signed [TRIG_FRAC_BITS+1:0]  cx,
  input  logic signed [TRIG_FRAC_BITS+1:0]  sy,
  input  logic signed [TRIG_FRAC_BITS+1:0]  cy,
  input  logic signed [TRIG_FRAC_BITS+1:0]  sz,
  input  logic signed [TRIG_FRAC_BITS+1:0]  cz,
  input  erm_pkg::row_t                     row_i,
  output logic                              out_vld,
  output logic signed [erm_pkg::ELEM_W-1:0] res0,
  output logic signed [erm_pkg::ELEM_W-1:0] res1,
  output logic signed [erm_pkg::ELEM_W-1:0] res2,
  output logic signed [erm_pkg::ELEM_W-1:0] res3
);

  localparam int T  = TRIG_FRAC_BITS;
  localparam int TW = T + 2;
  localparam int PW = 2 * TW;
  localparam int QW = PW + 1;
  localparam int RW = T + 3;
  localparam int EW = erm_pkg::ELEM_W;
  localparam int VW = EW + RW;
  localparam int SW = VW + 2;

  function automatic logic signed [TW-1:0] rnd_p(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + (PW'(1) <<< (T - 1))) >>> T;
    return t[TW-1:0];
  endfunction

  function automatic logic signed [RW-1:0] rnd_q(input logic signed [QW-1:0] p);
    logic signed [QW-1:0] t;
    t = (p + (QW'(1) <<< (T - 1))) >>> T;
    return t[RW-1:0];
  endfunction

  // stage 1: Ry*Rx products
  logic signed [PW-1:0] p_sysx, p_sycx, p_cysx, p_cycx;
  logic signed [TW-1:0] cy1, sy1, cx1, sx1, cz1, sz1;
  erm_pkg::row_t        row1;
  logic                 v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
    end
    if (en) begin
      p_sysx <= PW'(sy) * PW'(sx);
      p_sycx <= PW'(sy) * PW'(cx);
      p_cysx <= PW'(cy) * PW'(sx);
      p_cycx <= PW'(cy) * PW'(cx);
      cy1 <= cy; sy1 <= sy; cx1 <= cx; sx1 <= sx; cz1 <= cz; sz1 <= sz;
      row1 <= row_i;
    end
  end

  // stage 2: round M, then Rz products
  logic signed [TW-1:0] m0 [3];
  logic signed [TW-1:0] m1 [3];
  logic signed [TW-1:0] m2 [3];
  logic signed [PW-1:0] pa [3], pb [3], pc [3], pd [3];
  logic signed [TW-1:0] m2r [3];
  erm_pkg::row_t        row2;
  logic                 v2;

  always_comb begin
    m0[0] = cy1;
    m0[1] = rnd_p(p_sysx);
    m0[2] = rnd_p(p_sycx);
    m1[0] = '0;
    m1[1] = cx1;
    m1[2] = -sx1;
    m2[0] = -sy1;
    m2[1] = rnd_p(p_cysx);
    m2[2] = rnd_p(p_cycx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pa[j]  <= PW'(cz1) * PW'(m0[j]);
        pb[j]  <= PW'(sz1) * PW'(m1[j]);
        pc[j]  <= PW'(sz1) * PW'(m0[j]);
        pd[j]  <= PW'(cz1) * PW'(m1[j]);
        m2r[j] <= m2[j];
      end
      row2 <= row1;
    end
  end

  // stage 3: R entries
  logic signed [RW-1:0] r [3][3];
  erm_pkg::row_t        row3;
  logic                 v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        r[0][j] <= rnd_q(QW'(pa[j]) - QW'(pb[j]));
        r[1][j] <= rnd_q(QW'(pc[j]) + QW'(pd[j]));
        r[2][j] <= RW'(m2r[j]);
      end
      row3 <= row2;
    end
  end

  // stage 4: row times R
  logic signed [EW-1:0] vk [3];
  logic signed [VW-1:0] pv [3][3];
  logic signed [EW-1:0] e3_4;
  logic                 v4;

  assign vk[0] = row3.e0;
  assign vk[1] = row3.e1;
  assign vk[2] = row3.e2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          pv[k][j] <= VW'(vk[k]) * VW'(r[k][j]);
        end
      end
      e3_4 <= row3.e3;
    end
  end

  // stage 5: sum, round, saturate
  logic signed [SW-1:0] acc [3];
  logic signed [SW-1:0] sh  [3];
  logic signed [EW-1:0] sat [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc[j] = SW'(pv[0][j]) + SW'(pv[1][j]) + SW'(pv[2][j]);
      sh[j]  = (acc[j] + (SW'(1) <<< (T - 1))) >>> T;
      if ((&sh[j][SW-1:EW-1]) || !(|sh[j][SW-1:EW-1])) begin
        sat[j] = sh[j][EW-1:0];
      end else if (sh[j][SW-1]) begin
        sat[j] = {1'b1, {(EW-1){1'b0}}};
      end else begin
        sat[j] = {1'b0, {(EW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v4;
    end
    if (en) begin
      res0 <= sat[0];
      res1 <= sat[1];
      res2 <= sat[2];
      res3 <= e3_4;
    end
  end

endmodule

// ===== hw/rtl/euler_rotate_matrix_row.sv =====
// channel | signals                                  | handshake
// input   | angle_x/y/z, row_e0..row_e3              | in_valid / in_ready
// output  | res_e0..res_e3                           | out_valid / out_ready
//
// One word per cycle while the output word is not stalled; the sine/cosine pipeline,
// with its 28 cordic steps, comes first, then the matrix products.
// rst is synchronous and clears every valid bit; data registers are not reset.
// A single stall line freezes the whole pipeline while the output word waits,
// so in_ready is low only when out_valid is high and out_ready is low.
module euler_rotate_matrix_row #(
  parameter int TRIG_FRAC_BITS = erm_pkg::TRIG_FRAC_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [erm_pkg::ANGLE_W-1:0] angle_x,
  input  logic signed [erm_pkg::ANGLE_W-1:0] angle_y,
  input  logic signed [erm_pkg::ANGLE_W-1:0] angle_z,
  input  logic signed [erm_pkg::ELEM_W-1:0]  row_e0,
  input  logic signed [erm_pkg::ELEM_W-1:0]  row_e1,
  input  logic signed [erm_pkg::ELEM_W-1:0]  row_e2,
  input  logic signed [erm_pkg::ELEM_W-1:0]  row_e3,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [erm_pkg::ELEM_W-1:0]  res_e0,
  output logic signed [erm_pkg::ELEM_W-1:0]  res_e1,
  output logic signed [erm_pkg::ELEM_W-1:0]  res_e2,
  output logic signed [erm_pkg::ELEM_W-1:0]  res_e3
);

  localparam int TW  = TRIG_FRAC_BITS + 2;
  localparam int LAT = erm_pkg::TRIG_LAT;

  logic en;
  logic vx, vy, vz;
  logic signed [TW-1:0] sx, cx, sy, cy, sz, cz;
  erm_pkg::row_t row_dly [LAT];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  erm_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_x (
    .clk, .rst, .en, .in_vld(in_valid), .angle(angle_x),
    .out_vld(vx), .sin_o(sx), .cos_o(cx)
  );

  erm_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_y (
    .clk, .rst, .en, .in_vld(in_valid), .angle(angle_y),
    .out_vld(vy), .sin_o(sy), .cos_o(cy)
  );

  erm_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_z (
    .clk, .rst, .en, .in_vld(in_valid), .angle(angle_z),
    .out_vld(vz), .sin_o(sz), .cos_o(cz)
  );

  // row rides alongside the trig pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      row_dly[0] <= '{e0: row_e0, e1: row_e1, e2: row_e2, e3: row_e3};
      for (int i = 1; i < LAT; i++) begin
        row_dly[i] <= row_dly[i-1];
      end
    end
  end

  erm_rot #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot (
    .clk, .rst, .en,
    .in_vld(vx && vy && vz),
    .sx, .cx, .sy, .cy, .sz, .cz,
    .row_i(row_dly[LAT-1]),
    .out_vld(out_valid),
    .res0(res_e0), .res1(res_e1), .res2(res_e2), .res3(res_e3)
  );

endmodule

// ===== hw/rtl/erm_check.sv =====
module erm_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [erm_pkg::ELEM_W-1:0]  res_e0,
  input logic signed [erm_pkg::ELEM_W-1:0]  res_e1,
  input logic signed [erm_pkg::ELEM_W-1:0]  res_e2,
  input logic signed [erm_pkg::ELEM_W-1:0]  res_e3
);

  // stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_e0) && $stable(res_e1)
      && $stable(res_e2) && $stable(res_e3))
    else $error("output word changed under stall");

  // pipeline only stalls while the output word waits
  a_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind euler_rotate_matrix_row erm_check u_chk (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int TRIG_FRAC = erm_pkg::TRIG_FRAC_DEF;
  localparam int PIPE_LAT  = erm_pkg::TRIG_LAT + erm_pkg::ROT_LAT;
  localparam int AW        = erm_pkg::ANGLE_W;
  localparam int EW        = erm_pkg::ELEM_W;
  localparam int FULL      = erm_pkg::FULL_TURN;
  localparam int QUARTER   = erm_pkg::QUARTER_TURN;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [AW-1:0] angle_x = '0, angle_y = '0, angle_z = '0;
  logic signed [EW-1:0] row_e0 = '0, row_e1 = '0, row_e2 = '0, row_e3 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [EW-1:0] res_e0, res_e1, res_e2, res_e3;

  erm_pkg::row_t rotated_rows[$];
  int   errors = 0;
  bit   stall_mode = 1'b1;

  always #5 clk = ~clk;

  euler_rotate_matrix_row #(.TRIG_FRAC_BITS(TRIG_FRAC)) uut (.*);

  function automatic longint asr64(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_t(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // sine and cosine of one angle, Q(TRIG_FRAC), via the Q30 cordic
  task automatic angle_trig(input logic signed [AW-1:0] ang,
                            output longint sn, output longint cs);
    longint a, q, f, x, y, z, xs, ys, s, c;
    a = longint'(ang) % FULL;
    if (a < 0) a += FULL;
    q = a / QUARTER;
    f = a - q * QUARTER;
    if (f == 0) begin
      s = 0;
      c = 64'sd1 <<< TRIG_FRAC;
    end else begin
      x = 652032874;
      y = 0;
      z = longint'((64'(f) * 64'd9595049033 + 64'd32768) >> 16);
      for (int i = 0; i < erm_pkg::CORDIC_STEPS; i++) begin
        xs = asr64(x, i);
        ys = asr64(y, i);
        if (z >= 0) begin
          x -= ys; y += xs; z -= longint'(erm_pkg::ATAN_Q30[i]);
        end else begin
          x += ys; y -= xs; z += longint'(erm_pkg::ATAN_Q30[i]);
        end
      end
      c = round_t(x, 30 - TRIG_FRAC);
      s = round_t(y, 30 - TRIG_FRAC);
    end
    case (q)
      1: begin sn = c;  cs = -s; end
      2: begin sn = -s; cs = -c; end
      3: begin sn = -c; cs = s;  end
      default: begin sn = s; cs = c; end
    endcase
  endtask

  task automatic rotate_row(input logic signed [AW-1:0] ax, ay, az,
                            input erm_pkg::row_t v, output erm_pkg::row_t r_out);
    longint sx, cx, sy, cy, sz, cz, one, acc;
    longint rx[3][3], ry[3][3], rz[3][3], m[3][3], r[3][3];
    longint vv[3];
    logic signed [EW-1:0] o[3];
    angle_trig(ax, sx, cx);
    angle_trig(ay, sy, cy);
    angle_trig(az, sz, cz);
    one = 64'sd1 <<< TRIG_FRAC;
    rx = '{'{one, 0, 0}, '{0, cx, -sx}, '{0, sx, cx}};
    ry = '{'{cy, 0, sy}, '{0, one, 0}, '{-sy, 0, cy}};
    rz = '{'{cz, -sz, 0}, '{sz, cz, 0}, '{0, 0, one}};
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += ry[i][k] * rx[k][j];
        m[i][j] = round_t(acc, TRIG_FRAC);
      end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += rz[i][k] * m[k][j];
        r[i][j] = round_t(acc, TRIG_FRAC);
      end
    vv[0] = longint'(v.e0); vv[1] = longint'(v.e1); vv[2] = longint'(v.e2);
    for (int j = 0; j < 3; j++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += vv[k] * r[k][j];
      acc = round_t(acc, TRIG_FRAC);
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      o[j] = acc[31:0];
    end
    r_out = '{e0: o[0], e1: o[1], e2: o[2], e3: v.e3};
  endtask

  // receiver: stalls on its own pattern, or never when stall_mode is off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !stall_mode || ($urandom_range(0, 9) > 3);
    end
  end

  always @(posedge clk) begin
    erm_pkg::row_t want;
    if (!rst && out_valid && out_ready) begin
      if (rotated_rows.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        want = rotated_rows.pop_front();
        if (res_e0 !== want.e0) begin
          $error("res_e0 expected %0d got %0d", want.e0, res_e0); errors++;
        end
        if (res_e1 !== want.e1) begin
          $error("res_e1 expected %0d got %0d", want.e1, res_e1); errors++;
        end
        if (res_e2 !== want.e2) begin
          $error("res_e2 expected %0d got %0d", want.e2, res_e2); errors++;
        end
        if (res_e3 !== want.e3) begin
          $error("res_e3 expected %0d got %0d", want.e3, res_e3); errors++;
        end
      end
    end
  end

  task automatic send_word(input logic signed [AW-1:0] ax, ay, az, input erm_pkg::row_t v);
    erm_pkg::row_t r;
    rotate_row(ax, ay, az, v, r);
    in_valid <= 1'b1;
    angle_x <= ax; angle_y <= ay; angle_z <= az;
    row_e0 <= v.e0; row_e1 <= v.e1; row_e2 <= v.e2; row_e3 <= v.e3;
    do @(posedge clk); while (!in_ready);
    rotated_rows.push_back(r);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
  endtask

  function automatic logic signed [AW-1:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return -AW'(FULL);
      1: return AW'(FULL - 1);
      2: return AW'($urandom_range(0, 7) * QUARTER);
      3: return AW'($urandom);   // includes out of range raw codes
      default: return AW'(int'($urandom_range(0, 2 * FULL - 1)) - FULL);
    endcase
  endfunction

  function automatic logic signed [EW-1:0] rand_elem();
    case ($urandom_range(0, 4))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return EW'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic signed [AW-1:0] angs[8];
    erm_pkg::row_t big, unit;
    angs = '{17'sd0, 17'sd1, AW'(QUARTER), AW'(2 * QUARTER), AW'(3 * QUARTER),
             AW'(FULL - 1), -AW'(FULL), 17'sh10000};
    unit = '{e0: 32'sh10000, e1: 32'sh20000, e2: -32'sh30000, e3: 32'sh12345};
    big  = '{e0: 32'sh7FFFFFFF, e1: 32'sh7FFFFFFF, e2: 32'sh7FFFFFFF,
             e3: 32'sh80000000};
    for (int i = 0; i < 8; i++) send_word(angs[i], angs[7 - i], angs[(i + 3) % 8], unit);
    // 45 degrees on each axis pushes full-scale rows into saturation
    send_word(17'sd5760, 17'sd5760, 17'sd5760, big);
    send_word(17'sd5760, 17'sd5760, 17'sd5760, '{e0: 32'sh80000000, e1: 32'sh80000000,
                                                 e2: 32'sh80000000, e3: 32'sh7FFFFFFF});
    send_word(-17'sd5760, 17'sd5760, -17'sd5760, big);
    send_word(17'sh0FFFF, 17'sh10000, 17'sh1FFFF,
              '{e0: -32'sd1, e1: 32'sd0, e2: 32'sd1, e3: -32'sd1});
    go_idle();
  endtask

  task automatic test_random(input int n);
    int burst;
    int sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < n; i++, sent++)
        send_word(rand_angle(), rand_angle(), rand_angle(),
                  '{e0: rand_elem(), e1: rand_elem(), e2: rand_elem(), e3: rand_elem()});
      if ($urandom_range(0, 3) != 0) begin
        go_idle();
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    go_idle();
  endtask

  task automatic drain();
    while (rotated_rows.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain();
    test_random(600);
    drain();                      // sender holds off until the pipe is empty
    stall_mode = 1'b0;
    test_random(350);             // receiver always ready, no back-pressure
    stall_mode = 1'b1;
    test_random(400);
    drain();
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
